### sv/conv2d_5x5_zero_pad_assert.svh
// Assertion macros for the 5x5 convolution block.
// Used by conv2d_5x5_zero_pad.sv; expects clk_i and rst_ni in scope.
`ifndef CONV2D_5X5_ZERO_PAD_ASSERT_SVH
`define CONV2D_5X5_ZERO_PAD_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define C2D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define C2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### sv/c2d_pkg.sv
// Shared types and constants for the 5x5 zero-padded convolution.
// No dependencies; imported by conv2d_5x5_zero_pad.
`timescale 1ns / 1ps
`default_nettype none

package c2d_pkg;

  // Default geometry and arithmetic
  localparam int MAX_WIDTH_DEF      = 128;
  localparam int MAX_HEIGHT_DEF     = 4096;
  localparam int KERNEL_SIZE_DEF    = 5;
  localparam int COEF_FRAC_BITS_DEF = 10;

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 12;
  localparam int COEF_COLS  = 5;
  localparam int COEF_ROWS  = 5;
  localparam int VALUE_W    = 16;
  localparam int WIDTH_W    = 8;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W * COEF_COLS;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW4 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd6;

  // Reset values
  localparam logic [CFG_DATA_W-1:0] COEF_RESET   = 60'd11543292231716905;
  localparam logic [WIDTH_W-1:0]    WIDTH_RESET  = 8'd128;
  localparam logic [HEIGHT_W-1:0]   HEIGHT_RESET = 13'd128;

  // Per-beat control carried down the pipeline
  typedef struct packed {
    logic produce;
    logic last;
  } c2d_ctl_t;

endpackage

`default_nettype wire

### sv/conv2d_5x5_zero_pad.sv
// Streaming KxK convolution with zero padding, line stores in one memory.
// Depends on c2d_pkg and conv2d_5x5_zero_pad_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// Takes one pixel beat per clock and gives one result beat per clock while the
// output is not stalled, once the first 2*width+2 beats of an image are in; the
// producer closes each image with 2*width+2 flush beats. A beat passes five
// register stages: line-memory read, window shift, the 25 multiplies, row sums,
// and the final add with rounding into the output register. The line stores
// share one memory word per column, read once and written once per beat, which
// sets the rate at one beat per cycle while the output is not stalled.
// The whole pipeline advances when the output register is free or taken.
module conv2d_5x5_zero_pad #(
  parameter int MAX_WIDTH      = c2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT     = c2d_pkg::MAX_HEIGHT_DEF,
  parameter int KERNEL_SIZE    = c2d_pkg::KERNEL_SIZE_DEF,
  parameter int COEF_FRAC_BITS = c2d_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [c2d_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [c2d_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    req_type_i,
  input  logic [c2d_pkg::PIX_W-1:0]               pixel_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [c2d_pkg::VALUE_W-1:0]      value_o,
  output logic                                    last_o
);
  import c2d_pkg::*;

  localparam int HALF  = (KERNEL_SIZE - 1) / 2;
  localparam int LINES = KERNEL_SIZE - 1;
  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + HALF + 1);
  localparam int ORW   = $clog2(MAX_HEIGHT + 1);
  localparam int MW    = LINES * PIX_W;
  localparam int PW    = PIX_W + 1 + COEF_W;
  localparam int RSW   = PW + $clog2(KERNEL_SIZE);
  localparam int SW    = RSW + $clog2(KERNEL_SIZE);
  localparam logic signed [SW:0] RND =
    (COEF_FRAC_BITS > 0) ? (SW+1)'(1 << (COEF_FRAC_BITS - 1)) : '0;
  localparam logic signed [SW:0] SAT_HI = (SW+1)'(32767);
  localparam logic signed [SW:0] SAT_LO = -(SW+1)'(32768);

  // Configuration registers
  logic [CFG_DATA_W-1:0] coef_q [COEF_ROWS];
  logic [WIDTH_W-1:0]    width_q;
  logic [HEIGHT_W-1:0]   height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < COEF_ROWS; r++) coef_q[r] <= COEF_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COEF_ROW0: coef_q[0] <= cfg_data_i;
        REG_COEF_ROW1: coef_q[1] <= cfg_data_i;
        REG_COEF_ROW2: coef_q[2] <= cfg_data_i;
        REG_COEF_ROW3: coef_q[3] <= cfg_data_i;
        REG_COEF_ROW4: coef_q[4] <= cfg_data_i;
        REG_WIDTH:     width_q   <= cfg_data_i[WIDTH_W-1:0];
        REG_HEIGHT:    height_q  <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry in use
  logic [CW-1:0] w_use;
  logic [RW-1:0] h_use;

  always_comb begin
    if (32'(width_q) < KERNEL_SIZE)    w_use = CW'(KERNEL_SIZE);
    else if (32'(width_q) > MAX_WIDTH) w_use = CW'(MAX_WIDTH);
    else                               w_use = CW'(width_q);
    if (32'(height_q) < KERNEL_SIZE)     h_use = RW'(KERNEL_SIZE);
    else if (32'(height_q) > MAX_HEIGHT) h_use = RW'(MAX_HEIGHT);
    else                                 h_use = RW'(height_q);
  end

  // Pipeline advance: output register free or being taken
  logic en, accept;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  // Position counters
  logic [CW-1:0]  in_col_q, out_col_q;
  logic [RW-1:0]  in_row_q;
  logic [ORW-1:0] out_row_q;
  logic           produce_now, last_now;

  // Produce once the raster position has passed the first HALF rows plus HALF
  assign produce_now = (32'(in_row_q) * 32'(w_use) + 32'(in_col_q)) >=
                       (32'(HALF) * 32'(w_use) + 32'(HALF));
  assign last_now = produce_now &&
                    (32'(out_row_q) + 32'd1 >= 32'(h_use)) &&
                    (32'(out_col_q) + 32'd1 >= 32'(w_use));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (accept) begin
      if (last_now) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else begin
        if (produce_now) begin
          if (32'(out_col_q) + 32'd1 >= 32'(w_use)) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + ORW'(1);
          end else begin
            out_col_q <= out_col_q + CW'(1);
          end
        end
        if (32'(in_col_q) + 32'd1 >= 32'(w_use)) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + RW'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end
    end
  end

  // Tap masks for this beat's output position
  logic [KERNEL_SIZE-1:0] row_ok, col_ok;
  logic [LINES-1:0]       top_ok;

  always_comb begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      row_ok[r] = (32'(out_row_q) + r >= HALF) && (32'(out_row_q) + r < 32'(h_use) + HALF);
      col_ok[r] = (32'(out_col_q) + r >= HALF) && (32'(out_col_q) + r < 32'(w_use) + HALF);
    end
    for (int k = 0; k < LINES; k++) top_ok[k] = (32'(in_row_q) >= LINES - k);
  end

  // Stage 1: line memory read in flight
  logic                   v1_q;
  c2d_ctl_t               ctl1_q;
  logic [PIX_W-1:0]       pix1_q;
  logic [AW-1:0]          addr1_q;
  logic [LINES-1:0]       top1_q;
  logic [KERNEL_SIZE-1:0] row1_q, col1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctl1_q  <= '{produce: produce_now, last: last_now};
      pix1_q  <= req_type_i ? '0 : pixel_i;
      addr1_q <= in_col_q[AW-1:0];
      top1_q  <= top_ok;
      row1_q  <= row_ok;
      col1_q  <= col_ok;
    end
  end

  // Line memory: one word per column, all lines side by side. Consecutive
  // beats touch different columns, so read and write never meet on one entry.
  logic [MW-1:0]    line_mem [MAX_WIDTH];
  logic [MW-1:0]    rd_q, wr_word;
  logic [PIX_W-1:0] colv [KERNEL_SIZE];

  always_comb begin
    for (int k = 0; k < LINES; k++) colv[k] = top1_q[k] ? rd_q[k*PIX_W +: PIX_W] : '0;
    colv[LINES] = pix1_q;
    for (int k = 0; k < LINES; k++) wr_word[k*PIX_W +: PIX_W] = colv[k+1];
  end

  always_ff @(posedge clk_i) begin
    if (accept) rd_q <= line_mem[in_col_q[AW-1:0]];
    if (en && v1_q) line_mem[addr1_q] <= wr_word;
  end

  // Shift the window by one column
  logic [PIX_W-1:0] win_q [KERNEL_SIZE][KERNEL_SIZE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < KERNEL_SIZE; r++)
        for (int c = 0; c < KERNEL_SIZE; c++) win_q[r][c] <= '0;
    end else if (en && v1_q) begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        for (int c = 0; c < KERNEL_SIZE - 1; c++) win_q[r][c] <= win_q[r][c+1];
        win_q[r][KERNEL_SIZE-1] <= colv[r];
      end
    end
  end

  // Stage 2: window holds this beat; register masked products
  logic                   v2_q, v3_q, v4_q;
  c2d_ctl_t               ctl2_q, ctl3_q, ctl4_q;
  logic [KERNEL_SIZE-1:0] row2_q, col2_q;
  logic signed [PW-1:0]   prod_q [KERNEL_SIZE][KERNEL_SIZE];
  logic signed [RSW-1:0]  rsum_q [KERNEL_SIZE];
  logic signed [RSW-1:0]  rsum_d [KERNEL_SIZE];
  logic signed [SW-1:0]   sum_d;
  logic signed [SW:0]     biased, shifted;
  logic signed [VALUE_W-1:0] value_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl2_q <= ctl1_q;
      row2_q <= row1_q;
      col2_q <= col1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        for (int c = 0; c < KERNEL_SIZE; c++) begin
          if (row2_q[r] && col2_q[c])
            prod_q[r][c] <= $signed({1'b0, win_q[r][c]}) *
                            $signed(coef_q[r][c*COEF_W +: COEF_W]);
          else
            prod_q[r][c] <= '0;
        end
        rsum_q[r] <= rsum_d[r];
      end
    end
  end

  // Stage 3: row sums
  always_comb begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      rsum_d[r] = '0;
      for (int c = 0; c < KERNEL_SIZE; c++) rsum_d[r] = rsum_d[r] + RSW'(prod_q[r][c]);
    end
  end

  // Stage 4: total, round half up, saturate
  always_comb begin
    sum_d = '0;
    for (int r = 0; r < KERNEL_SIZE; r++) sum_d = sum_d + SW'(rsum_q[r]);
    biased  = (SW+1)'(sum_d) + RND;
    shifted = biased >>> COEF_FRAC_BITS;
    if (shifted > SAT_HI)      value_d = VALUE_W'(SAT_HI);
    else if (shifted < SAT_LO) value_d = VALUE_W'(SAT_LO);
    else                       value_d = VALUE_W'(shifted);
  end

  // Output register
  logic out_valid_q, last_q;
  logic signed [VALUE_W-1:0] value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= v4_q && ctl4_q.produce;
  end

  always_ff @(posedge clk_i) begin
    if (en && v4_q && ctl4_q.produce) begin
      value_q <= value_d;
      last_q  <= ctl4_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

  `include "conv2d_5x5_zero_pad_assert.svh"

  `C2D_ASSERT(a_ready_follows_output, in_ready_o == (!out_valid_o || out_ready_i), "input ready must track output register state")
  `C2D_ASSERT_NEXT(a_result_from_pipe, en && v4_q && ctl4_q.produce, out_valid_o, "finished beat must reach the output register")
  `C2D_ASSERT_NEXT(a_last_clears_counters, accept && last_now, (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0), "last beat must restart the image counters")
  `C2D_ASSERT_NEXT(a_no_spurious_result, en && !(v4_q && ctl4_q.produce), !out_valid_o, "output valid without a finished beat")

endmodule

`default_nettype wire
